// File: hdl/mcfa_pkg.sv
// Package for the multi-camera frame aligner: item types, codes, state machine
// and controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package mcfa_pkg;

	typedef struct packed {
		logic        operation;
		logic [1:0]  camera;
		logic [31:0] frame_id;
		logic [15:0] buffer_tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  disposition;
		logic [1:0]  out_camera;
		logic [31:0] out_frame_id;
		logic [15:0] out_tag;
		logic        last;
	} out_item_t;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_DECIDE = 1'b1;

	localparam logic [1:0] REG_VIEW_COUNT   = 2'd0;
	localparam logic [1:0] REG_RETAIN_LIMIT = 2'd1;

	localparam logic [2:0] VIEW_COUNT_RESET   = 3'd4;
	localparam logic [4:0] RETAIN_LIMIT_RESET = 5'd12;

	localparam int        VIEWW       = 4;
	localparam int        TALLYW      = 7;
	localparam int        RESW        = 7;
	localparam logic [6:0] TALLY_MAX  = 7'd127;
	localparam logic [6:0] MAX_RESULTS = 7'd64;

	typedef enum logic [1:0] {
		DISP_CHOSEN = 2'd0,
		DISP_STALE  = 2'd1,
		DISP_REJECT = 2'd2
	} disp_t;

	typedef enum logic [1:0] {
		SCAN_MATCH,
		SCAN_OLDEST,
		SCAN_TALLY,
		SCAN_PURGE
	} scan_mode_t;

	typedef enum logic [1:0] {
		KEY_ITEM,
		KEY_FID,
		KEY_MAX,
		KEY_HIT
	} key_sel_t;

	typedef enum logic [1:0] {
		EMIT_ITEM,
		EMIT_DUP,
		EMIT_HIT
	} emit_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ARR_SCAN,
		S_TAL_SCAN,
		S_CHO_SCAN,
		S_REL_SCAN,
		S_PURGE,
		S_TRIM_SCAN,
		S_TDEC_SCAN,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic       latch;
		logic       scan_go;
		scan_mode_t scan_mode;
		key_sel_t   key_sel;
		logic       cam_load_item;
		logic       cam_clr;
		logic       cam_inc;
		logic       ent_insert;
		logic       ent_dup;
		logic       ent_kill;
		logic       tal_bump;
		logic       tal_dec;
		logic       emit;
		emit_src_t  emit_src;
		disp_t      emit_disp;
		logic       flush;
		logic       clr_complete;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic free_found;
		logic cnt_over;
		logic complete;
		logic op_decide;
		logic reject;
		logic cam_end_views;
		logic cam_end_all;
	} stat_t;

endpackage

// File: hdl/multi_camera_frame_aligner.sv
// Top level of the multi-camera frame aligner: controller plus datapath.
// Uses mcfa_pkg, mcfa_ctrl, mcfa_datapath.
`timescale 1ns / 1ps

// Takes one item at a time (start while busy is low) and stays busy until its work is
// done. Table scans run one entry a cycle through the registered-read table memories. With
// D = TABLE_DEPTH and N = MAX_VIEWS * TABLE_DEPTH, a stored arrival scans its camera table
// of D entries and then the N tally entries, a repeated id only its camera table, and an
// arrival for a camera beyond the view count nothing; a decide scans once per camera table,
// once more per released or trimmed buffer, and sweeps the N tally entries once (a trim
// sweeps the tally once per trimmed buffer instead). At most one result comes per scan and
// each is held until the next one or the end of the item; each is marked by result_strobe
// for one cycle and the final one, with last set, shows in the first cycle after busy
// falls. The receiver cannot stall, so take each result in the cycle it is shown. No
// clearing pass after reset is needed.
module multi_camera_frame_aligner #(
	parameter int MAX_VIEWS   = 4,
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mcfa_pkg::in_item_t  item,
	output logic                result_strobe,
	output mcfa_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [4:0]          cfg_data
);

	mcfa_pkg::cmd_t  cmd;
	mcfa_pkg::stat_t stat;

	mcfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	mcfa_datapath #(
		.MAX_VIEWS   (MAX_VIEWS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

// File: hdl/mcfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mcfa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/mcfa_datapath.sv
// Datapath of the frame aligner: camera tables, tally store, scan engine,
// completion tracking, config registers and result holding. Uses mcfa_pkg, mcfa_ram.
`timescale 1ns / 1ps

module mcfa_datapath #(
	parameter int MAX_VIEWS   = 4,
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mcfa_pkg::in_item_t item,
	input  mcfa_pkg::cmd_t     cmd,
	output mcfa_pkg::stat_t    stat,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	output logic               result_strobe,
	output mcfa_pkg::out_item_t result
);

	localparam int SLOTS = MAX_VIEWS * TABLE_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int IW    = $clog2(SLOTS + 1);
	localparam int CCW   = $clog2(MAX_VIEWS + 1);
	localparam int SW    = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW  = (SW > 5) ? SW : 5;
	localparam int VW    = mcfa_pkg::VIEWW;
	localparam int TW    = mcfa_pkg::TALLYW;

	// config
	logic [2:0] view_count_q;
	logic [4:0] retain_q;
	logic [VW-1:0] views;

	// item and camera
	mcfa_pkg::in_item_t item_q;
	logic [CCW-1:0] cam_q, cam_nxt;

	// scan engine
	logic                 run_q, p_s1, last_s1, done_q;
	logic [IW-1:0]        idx_q, len_q;
	logic [AW-1:0]        base_q, raddr, addr_s1;
	mcfa_pkg::scan_mode_t mode_q;
	logic [31:0]          key_q, key_nxt;
	logic                 is_last;

	// scan results
	logic          found_q, free_found_q;
	logic [AW-1:0] hit_addr_q, free_addr_q;
	logic [31:0]   hit_id_q;
	logic [15:0]   hit_tag_q;
	logic [TW-1:0] hit_val_q;
	logic [SW-1:0] count_q;

	// stores
	logic          entry_valid_q [SLOTS];
	logic          tally_valid_q [SLOTS];
	logic [47:0]   ent_rd, ent_wdata;
	logic [AW-1:0] ent_waddr;
	logic          ent_we;
	logic [38:0]   tal_rd, tal_wdata;
	logic [AW-1:0] tal_waddr;
	logic          tal_we;

	logic          tally_mode;
	logic          cur_v;
	logic [31:0]   cur_id;

	// completion
	logic          complete_q;
	logic [31:0]   newest_q;
	logic [TW-1:0] newv;

	// results
	logic                 pend_valid_q, strobe_q, do_emit;
	logic [mcfa_pkg::RESW-1:0] res_cnt_q;
	mcfa_pkg::out_item_t  pend_q, result_q, emit_data;

	// effective view count, clamped to 1..MAX_VIEWS
	always_comb begin
		if (view_count_q == 3'd0) begin
			views = VW'(1);
		end else if (VW'(view_count_q) > VW'(MAX_VIEWS)) begin
			views = VW'(MAX_VIEWS);
		end else begin
			views = VW'(view_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_count_q <= mcfa_pkg::VIEW_COUNT_RESET;
			retain_q     <= mcfa_pkg::RETAIN_LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mcfa_pkg::REG_VIEW_COUNT) begin
				view_count_q <= cfg_data[2:0];
			end else if (cfg_index == mcfa_pkg::REG_RETAIN_LIMIT) begin
				retain_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
	end

	always_comb begin
		cam_nxt = cam_q;
		if (cmd.cam_load_item) begin
			cam_nxt = CCW'(item_q.camera);
		end else if (cmd.cam_clr) begin
			cam_nxt = '0;
		end else if (cmd.cam_inc) begin
			cam_nxt = cam_q + CCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= '0;
		end else begin
			cam_q <= cam_nxt;
		end
	end

	always_comb begin
		unique case (cmd.key_sel)
			mcfa_pkg::KEY_ITEM: key_nxt = item_q.frame_id;
			mcfa_pkg::KEY_FID:  key_nxt = newest_q;
			mcfa_pkg::KEY_MAX:  key_nxt = '1;
			mcfa_pkg::KEY_HIT:  key_nxt = hit_id_q;
			default:            key_nxt = '1;
		endcase
	end

	assign raddr   = base_q + idx_q[AW-1:0];
	assign is_last = (idx_q == len_q - IW'(1));

	// scan sequencing: one address per cycle, compared in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			p_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			len_q   <= '0;
			base_q  <= '0;
			mode_q  <= mcfa_pkg::SCAN_MATCH;
			key_q   <= '0;
		end else begin
			p_s1    <= run_q;
			last_s1 <= run_q && is_last;
			done_q  <= p_s1 && last_s1;
			if (cmd.scan_go) begin
				run_q  <= 1'b1;
				idx_q  <= '0;
				mode_q <= cmd.scan_mode;
				key_q  <= key_nxt;
				if (cmd.scan_mode == mcfa_pkg::SCAN_TALLY ||
				    cmd.scan_mode == mcfa_pkg::SCAN_PURGE) begin
					len_q  <= IW'(SLOTS);
					base_q <= '0;
				end else begin
					len_q  <= IW'(TABLE_DEPTH);
					base_q <= AW'(cam_nxt * TABLE_DEPTH);
				end
			end else if (run_q) begin
				idx_q <= idx_q + IW'(1);
				if (is_last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
	end

	assign tally_mode = (mode_q == mcfa_pkg::SCAN_TALLY) || (mode_q == mcfa_pkg::SCAN_PURGE);
	assign cur_v      = tally_mode ? tally_valid_q[addr_s1] : entry_valid_q[addr_s1];
	assign cur_id     = tally_mode ? tal_rd[38:7] : ent_rd[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
		end else if (cmd.scan_go) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
		end else if (p_s1) begin
			if (cur_v) begin
				count_q <= count_q + SW'(1);
			end
			unique case (mode_q)
				mcfa_pkg::SCAN_MATCH, mcfa_pkg::SCAN_TALLY: begin
					if (cur_v && cur_id == key_q && !found_q) begin
						found_q <= 1'b1;
					end
					if (!cur_v && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				mcfa_pkg::SCAN_OLDEST: begin
					if (cur_v && cur_id <= key_q && (!found_q || cur_id < hit_id_q)) begin
						found_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (p_s1) begin
			unique case (mode_q)
				mcfa_pkg::SCAN_MATCH, mcfa_pkg::SCAN_TALLY: begin
					if (cur_v && cur_id == key_q && !found_q) begin
						hit_addr_q <= addr_s1;
						hit_id_q   <= cur_id;
						hit_tag_q  <= ent_rd[15:0];
						hit_val_q  <= tal_rd[6:0];
					end
					if (!cur_v && !free_found_q) begin
						free_addr_q <= addr_s1;
					end
				end
				mcfa_pkg::SCAN_OLDEST: begin
					if (cur_v && cur_id <= key_q && (!found_q || cur_id < hit_id_q)) begin
						hit_addr_q <= addr_s1;
						hit_id_q   <= cur_id;
						hit_tag_q  <= ent_rd[15:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// tally value after an increment; zero when no slot was found
	always_comb begin
		if (found_q) begin
			newv = (hit_val_q == mcfa_pkg::TALLY_MAX) ? hit_val_q : hit_val_q + TW'(1);
		end else if (free_found_q) begin
			newv = TW'(1);
		end else begin
			newv = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				entry_valid_q[i] <= 1'b0;
				tally_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.ent_insert) begin
				entry_valid_q[free_addr_q] <= 1'b1;
			end
			if (cmd.ent_kill) begin
				entry_valid_q[hit_addr_q] <= 1'b0;
			end
			if (cmd.tal_bump && !found_q && free_found_q) begin
				tally_valid_q[free_addr_q] <= 1'b1;
			end
			if (cmd.tal_dec && found_q && hit_val_q <= TW'(1)) begin
				tally_valid_q[hit_addr_q] <= 1'b0;
			end
			if (p_s1 && mode_q == mcfa_pkg::SCAN_PURGE && cur_v && cur_id <= key_q) begin
				tally_valid_q[addr_s1] <= 1'b0;
			end
		end
	end

	assign ent_we    = cmd.ent_insert || cmd.ent_dup;
	assign ent_waddr = cmd.ent_insert ? free_addr_q : hit_addr_q;
	assign ent_wdata = {item_q.frame_id, item_q.buffer_tag};

	always_comb begin
		tal_we    = 1'b0;
		tal_waddr = hit_addr_q;
		tal_wdata = {key_q, newv};
		if (cmd.tal_bump && (found_q || free_found_q)) begin
			tal_we    = 1'b1;
			tal_waddr = found_q ? hit_addr_q : free_addr_q;
		end else if (cmd.tal_dec && found_q && hit_val_q > TW'(1)) begin
			tal_we    = 1'b1;
			tal_wdata = {hit_id_q, hit_val_q - TW'(1)};
		end
	end

	mcfa_ram #(.WIDTH(48), .DEPTH(SLOTS)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (raddr),
		.rdata (ent_rd)
	);

	mcfa_ram #(.WIDTH(39), .DEPTH(SLOTS)) u_tally_ram (
		.clk   (clk),
		.we    (tal_we),
		.waddr (tal_waddr),
		.wdata (tal_wdata),
		.raddr (raddr),
		.rdata (tal_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complete_q <= 1'b0;
			newest_q   <= '0;
		end else if (cmd.clr_complete) begin
			complete_q <= 1'b0;
			newest_q   <= '0;
		end else if (cmd.tal_bump && newv == TW'(views) && (!complete_q || key_q > newest_q)) begin
			complete_q <= 1'b1;
			newest_q   <= key_q;
		end
	end

	// result source
	always_comb begin
		emit_data.disposition = cmd.emit_disp;
		emit_data.last        = 1'b0;
		unique case (cmd.emit_src)
			mcfa_pkg::EMIT_ITEM: begin
				emit_data.out_camera   = item_q.camera;
				emit_data.out_frame_id = item_q.frame_id;
				emit_data.out_tag      = item_q.buffer_tag;
			end
			mcfa_pkg::EMIT_DUP: begin
				emit_data.out_camera   = item_q.camera;
				emit_data.out_frame_id = item_q.frame_id;
				emit_data.out_tag      = hit_tag_q;
			end
			default: begin
				emit_data.out_camera   = 2'(cam_q);
				emit_data.out_frame_id = hit_id_q;
				emit_data.out_tag      = hit_tag_q;
			end
		endcase
	end

	assign do_emit = cmd.emit && (res_cnt_q < mcfa_pkg::MAX_RESULTS);

	// one result held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
			res_cnt_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (do_emit) begin
				pend_valid_q <= 1'b1;
				res_cnt_q    <= res_cnt_q + mcfa_pkg::RESW'(1);
				if (pend_valid_q) begin
					strobe_q <= 1'b1;
				end
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
				res_cnt_q    <= '0;
				if (pend_valid_q) begin
					strobe_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			pend_q   <= emit_data;
			result_q <= pend_q;
		end else if (cmd.flush) begin
			// last is the low bit of the result item
			result_q <= {pend_q[$bits(mcfa_pkg::out_item_t)-1:1], 1'b1};
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	assign stat.scan_done     = done_q;
	assign stat.found         = found_q;
	assign stat.free_found    = free_found_q;
	assign stat.cnt_over      = CMPW'(count_q) > CMPW'(retain_q);
	assign stat.complete      = complete_q;
	assign stat.op_decide     = (item_q.operation == mcfa_pkg::OP_DECIDE);
	assign stat.reject        = VW'(item_q.camera) >= views;
	assign stat.cam_end_views = (VW'(cam_q) + VW'(1)) >= views;
	assign stat.cam_end_all   = (cam_q == CCW'(MAX_VIEWS - 1));

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= mcfa_pkg::MAX_RESULTS)
		else $error("result count beyond limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> !pend_valid_q)
		else $error("held result left after final item");

	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_go |-> !run_q && !p_s1)
		else $error("scan started while another runs");

	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ent_insert |-> !entry_valid_q[free_addr_q] && free_found_q)
		else $error("insert into occupied slot");

endmodule

// File: hdl/mcfa_ctrl.sv
// Controller state machine of the frame aligner: sequences table scans,
// tally updates and result emission. Uses mcfa_pkg.
`timescale 1ns / 1ps

module mcfa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mcfa_pkg::stat_t stat,
	output logic            busy,
	output mcfa_pkg::cmd_t  cmd
);

	mcfa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcfa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcfa_pkg::S_IDLE: begin
				if (start) begin
					state_d = mcfa_pkg::S_DISPATCH;
				end
			end
			mcfa_pkg::S_DISPATCH: begin
				if (!stat.op_decide) begin
					state_d = stat.reject ? mcfa_pkg::S_FLUSH : mcfa_pkg::S_ARR_SCAN;
				end else begin
					state_d = stat.complete ? mcfa_pkg::S_CHO_SCAN : mcfa_pkg::S_TRIM_SCAN;
				end
			end
			mcfa_pkg::S_ARR_SCAN: begin
				if (stat.scan_done) begin
					state_d = (!stat.found && stat.free_found) ? mcfa_pkg::S_TAL_SCAN
					                                          : mcfa_pkg::S_FLUSH;
				end
			end
			mcfa_pkg::S_TAL_SCAN: begin
				if (stat.scan_done) begin
					state_d = mcfa_pkg::S_FLUSH;
				end
			end
			mcfa_pkg::S_CHO_SCAN: begin
				if (stat.scan_done && stat.cam_end_views) begin
					state_d = mcfa_pkg::S_REL_SCAN;
				end
			end
			mcfa_pkg::S_REL_SCAN: begin
				if (stat.scan_done && !stat.found && stat.cam_end_all) begin
					state_d = mcfa_pkg::S_PURGE;
				end
			end
			mcfa_pkg::S_PURGE: begin
				if (stat.scan_done) begin
					state_d = mcfa_pkg::S_FLUSH;
				end
			end
			mcfa_pkg::S_TRIM_SCAN: begin
				if (stat.scan_done) begin
					if (stat.cnt_over && stat.found) begin
						state_d = mcfa_pkg::S_TDEC_SCAN;
					end else if (stat.cam_end_all) begin
						state_d = mcfa_pkg::S_FLUSH;
					end
				end
			end
			mcfa_pkg::S_TDEC_SCAN: begin
				if (stat.scan_done) begin
					state_d = mcfa_pkg::S_TRIM_SCAN;
				end
			end
			mcfa_pkg::S_FLUSH: begin
				state_d = mcfa_pkg::S_IDLE;
			end
			default: begin
				state_d = mcfa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != mcfa_pkg::S_IDLE);
		unique case (state_q)
			mcfa_pkg::S_IDLE: begin
				cmd.latch = start;
			end
			mcfa_pkg::S_DISPATCH: begin
				if (!stat.op_decide) begin
					if (stat.reject) begin
						cmd.emit      = 1'b1;
						cmd.emit_src  = mcfa_pkg::EMIT_ITEM;
						cmd.emit_disp = mcfa_pkg::DISP_REJECT;
					end else begin
						cmd.cam_load_item = 1'b1;
						cmd.scan_go       = 1'b1;
						cmd.scan_mode     = mcfa_pkg::SCAN_MATCH;
						cmd.key_sel       = mcfa_pkg::KEY_ITEM;
					end
				end else begin
					cmd.cam_clr = 1'b1;
					cmd.scan_go = 1'b1;
					if (stat.complete) begin
						cmd.scan_mode = mcfa_pkg::SCAN_MATCH;
						cmd.key_sel   = mcfa_pkg::KEY_FID;
					end else begin
						cmd.scan_mode = mcfa_pkg::SCAN_OLDEST;
						cmd.key_sel   = mcfa_pkg::KEY_MAX;
					end
				end
			end
			mcfa_pkg::S_ARR_SCAN: begin
				if (stat.scan_done) begin
					if (stat.found) begin
						// same id already held: old buffer goes back, new tag replaces it
						cmd.emit      = 1'b1;
						cmd.emit_src  = mcfa_pkg::EMIT_DUP;
						cmd.emit_disp = mcfa_pkg::DISP_STALE;
						cmd.ent_dup   = 1'b1;
					end else if (stat.free_found) begin
						cmd.ent_insert = 1'b1;
						cmd.scan_go    = 1'b1;
						cmd.scan_mode  = mcfa_pkg::SCAN_TALLY;
						cmd.key_sel    = mcfa_pkg::KEY_ITEM;
					end else begin
						cmd.emit      = 1'b1;
						cmd.emit_src  = mcfa_pkg::EMIT_ITEM;
						cmd.emit_disp = mcfa_pkg::DISP_REJECT;
					end
				end
			end
			mcfa_pkg::S_TAL_SCAN: begin
				cmd.tal_bump = stat.scan_done;
			end
			mcfa_pkg::S_CHO_SCAN: begin
				if (stat.scan_done) begin
					if (stat.found) begin
						cmd.emit      = 1'b1;
						cmd.emit_src  = mcfa_pkg::EMIT_HIT;
						cmd.emit_disp = mcfa_pkg::DISP_CHOSEN;
						cmd.ent_kill  = 1'b1;
					end
					cmd.scan_go = 1'b1;
					cmd.key_sel = mcfa_pkg::KEY_FID;
					if (stat.cam_end_views) begin
						cmd.cam_clr   = 1'b1;
						cmd.scan_mode = mcfa_pkg::SCAN_OLDEST;
					end else begin
						cmd.cam_inc   = 1'b1;
						cmd.scan_mode = mcfa_pkg::SCAN_MATCH;
					end
				end
			end
			mcfa_pkg::S_REL_SCAN: begin
				if (stat.scan_done) begin
					cmd.scan_go = 1'b1;
					cmd.key_sel = mcfa_pkg::KEY_FID;
					if (stat.found) begin
						// rescan the same camera for the next oldest
						cmd.emit      = 1'b1;
						cmd.emit_src  = mcfa_pkg::EMIT_HIT;
						cmd.emit_disp = mcfa_pkg::DISP_STALE;
						cmd.ent_kill  = 1'b1;
						cmd.scan_mode = mcfa_pkg::SCAN_OLDEST;
					end else if (stat.cam_end_all) begin
						cmd.scan_mode = mcfa_pkg::SCAN_PURGE;
					end else begin
						cmd.cam_inc   = 1'b1;
						cmd.scan_mode = mcfa_pkg::SCAN_OLDEST;
					end
				end
			end
			mcfa_pkg::S_PURGE: begin
				cmd.clr_complete = stat.scan_done;
			end
			mcfa_pkg::S_TRIM_SCAN: begin
				if (stat.scan_done) begin
					if (stat.cnt_over && stat.found) begin
						cmd.emit      = 1'b1;
						cmd.emit_src  = mcfa_pkg::EMIT_HIT;
						cmd.emit_disp = mcfa_pkg::DISP_STALE;
						cmd.ent_kill  = 1'b1;
						cmd.scan_go   = 1'b1;
						cmd.scan_mode = mcfa_pkg::SCAN_TALLY;
						cmd.key_sel   = mcfa_pkg::KEY_HIT;
					end else if (stat.cam_end_all) begin
						cmd.clr_complete = 1'b1;
					end else begin
						cmd.cam_inc   = 1'b1;
						cmd.scan_go   = 1'b1;
						cmd.scan_mode = mcfa_pkg::SCAN_OLDEST;
						cmd.key_sel   = mcfa_pkg::KEY_MAX;
					end
				end
			end
			mcfa_pkg::S_TDEC_SCAN: begin
				if (stat.scan_done) begin
					cmd.tal_dec   = 1'b1;
					cmd.scan_go   = 1'b1;
					cmd.scan_mode = mcfa_pkg::SCAN_OLDEST;
					cmd.key_sel   = mcfa_pkg::KEY_MAX;
				end
			end
			mcfa_pkg::S_FLUSH: begin
				cmd.flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == mcfa_pkg::S_DISPATCH)
		else $error("accepted item not dispatched");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mcfa_pkg::S_FLUSH |=> !busy)
		else $error("flush not followed by idle");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ent_insert && (cmd.ent_dup || cmd.ent_kill)))
		else $error("conflicting table writes");

endmodule
